// ===== src/y4m_sd_pkg.sv =====
// shared types, constants and helpers for the y4m stream deframer
// used by every module of the block; depends on nothing
`default_nettype none

package y4m_sd_pkg;

   // header search window in bytes
   localparam int HEADER_WINDOW = 100;
   localparam int HDR_CNT_W     = $clog2(HEADER_WINDOW + 1);

   // field widths
   localparam int DIM_W       = 16;
   localparam int RATE_W      = 20;
   localparam int TICK_W      = 17;
   localparam int CHUNK_W     = 17;
   localparam int FRAME_LEN_W = 33;
   localparam int COUNT_W     = 32;
   localparam int TIME_W      = 40;
   localparam int PROD_W      = 2 * DIM_W;
   localparam int DIV_CNT_W   = $clog2(TICK_W);

   localparam logic [TICK_W-1:0]  TICK_RATE   = 17'd90000;
   localparam logic [CHUNK_W-1:0] CHUNK_MAX   = 17'd65536;
   localparam logic [CHUNK_W-1:0] CHUNK_RESET = 17'd8192;

   // frame tag "FRAME\n"
   localparam logic [2:0] TAG_LAST = 3'd5;
   localparam logic [2:0] TAG_LEN  = 3'd6;

   // command queue between parser and emitter
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int         CSR_ADDR_W    = 3;
   localparam int         CSR_DATA_W    = 32;
   localparam logic       CSR_IDX_CHUNK = 1'b0;

   typedef enum logic [1:0] {
      KIND_HDR_OK     = 2'd0,
      KIND_PAYLOAD    = 2'd1,
      KIND_HDR_REJECT = 2'd2,
      KIND_BAD_MARKER = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      PH_SEEK_W     = 3'd0,
      PH_SEEK_H     = 3'd1,
      PH_SEEK_F     = 3'd2,
      PH_SEEK_FRAME = 3'd3,
      PH_MARKER     = 3'd4,
      PH_PAYLOAD    = 3'd5,
      PH_DONE       = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      NUM_LEAD   = 2'd0,
      NUM_DIGITS = 2'd1,
      NUM_ENDED  = 2'd2,
      NUM_NEG    = 2'd3
   } num_state_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_DIVIDE = 2'd1,
      BK_EMIT   = 2'd2
   } back_state_type;

   typedef struct packed {
      logic [7:0] stream_byte;
      logic       restart;
   } req_item_type;

   typedef struct packed {
      kind_type            kind;
      logic [7:0]          payload_byte;
      logic [TIME_W-1:0]   frame_time;
      logic                chunk_end;
      logic                frame_end;
      logic [DIM_W-1:0]    frame_width;
      logic [DIM_W-1:0]    frame_height;
      logic [TICK_W-1:0]   tick_step;
   } rsp_item_type;

   // one classified byte on its way to the emitter
   typedef struct packed {
      kind_type            kind;
      logic [7:0]          data;
      logic                chunk_end;
      logic                frame_end;
      logic [DIM_W-1:0]    width;
      logic [DIM_W-1:0]    height;
      logic [RATE_W-1:0]   rate;
   } cmd_type;

   function automatic logic [7:0] frame_tag(input logic [2:0] idx);
      logic [7:0] ch;
      unique case (idx)
         3'd0:    ch = 8'h46;
         3'd1:    ch = 8'h52;
         3'd2:    ch = 8'h41;
         3'd3:    ch = 8'h4D;
         3'd4:    ch = 8'h45;
         3'd5:    ch = 8'h0A;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

`default_nettype wire

// ===== src/y4m_stream_deframer_unit.sv =====
// YUV4MPEG2 byte stream deframer.
// Input channel req_* takes one stream byte per transaction, with a restart flag that
// begins a new stream at that byte. Result channel rsp_* gives at most one result per
// byte: header accepted (width, height, tick step), payload byte with frame time and
// chunk/frame end marks, header rejected, or bad frame marker.
// A payload byte's result passes through the command queue and then the result register;
// bytes are taken one per cycle while the four-entry command queue has room.
// A header-accepted result waits for the tick step, which comes from a
// one-bit-per-cycle divider that runs once per stream; the parser keeps
// taking bytes until the queue fills behind it.
// A stall on rsp_stall holds the result register, then fills the queue, then raises
// req_stall; nothing is dropped.
// Reset (synchronous) sets chunk_bytes to 8192 and the parser to the width search.
// The csr_* port holds chunk_bytes at byte address 0; write it only while idle.
// Depends on y4m_sd_pkg, y4m_sd_front, y4m_sd_queue and y4m_sd_back.
`default_nettype none

module y4m_stream_deframer_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  y4m_sd_pkg::req_item_type             req_item,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output y4m_sd_pkg::rsp_item_type             rsp_item,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [y4m_sd_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [y4m_sd_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [y4m_sd_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                 csr_pready
);

   localparam int CW = y4m_sd_pkg::CHUNK_W;
   localparam int DW = y4m_sd_pkg::CSR_DATA_W;

   logic [CW-1:0]       chunk_ff, chunk_in;
   logic                csr_hit;
   logic                push_valid, queue_full, queue_pop, queue_empty;
   y4m_sd_pkg::cmd_type push_item, queue_item;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == y4m_sd_pkg::CSR_IDX_CHUNK);
   assign csr_prdata = csr_hit ? {{(DW-CW){1'b0}}, chunk_ff} : '0;

   always_comb begin
      chunk_in = chunk_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         chunk_in = csr_pwdata[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_ff <= y4m_sd_pkg::CHUNK_RESET;
      end else begin
         chunk_ff <= chunk_in;
      end
   end

   y4m_sd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .chunk_bytes (chunk_ff),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   y4m_sd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (queue_pop),
      .pop_item   (queue_item),
      .empty      (queue_empty)
   );

   y4m_sd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_empty (queue_empty),
      .queue_item  (queue_item),
      .queue_pop   (queue_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item)
   );

endmodule

`default_nettype wire

// ===== src/y4m_sd_front.sv =====
// byte parser: header search, number reading, frame tag check and payload counting
// pushes one classified command per result into the queue; uses y4m_sd_pkg
`default_nettype none

module y4m_sd_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  y4m_sd_pkg::req_item_type            req_item,
   input  logic [y4m_sd_pkg::CHUNK_W-1:0]      chunk_bytes,
   input  logic                                queue_full,
   output logic                                push_valid,
   output y4m_sd_pkg::cmd_type                 push_item
);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_W     = 8'h57;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_F     = 8'h46;

   localparam int DW = y4m_sd_pkg::DIM_W;
   localparam int RW = y4m_sd_pkg::RATE_W;
   localparam int CW = y4m_sd_pkg::CHUNK_W;
   localparam int LW = y4m_sd_pkg::FRAME_LEN_W;
   localparam int HW = y4m_sd_pkg::HDR_CNT_W;
   localparam int PW = y4m_sd_pkg::PROD_W;

   typedef struct packed {
      logic [RW-1:0]             acc;
      y4m_sd_pkg::num_state_type st;
   } num_result_type;

   function automatic num_result_type num_step(
      input logic [RW-1:0]             acc,
      input y4m_sd_pkg::num_state_type st,
      input logic [7:0]                b,
      input logic [RW-1:0]             maxv
   );
      num_result_type r;
      logic           go_digits;
      logic [RW+3:0]  v;
      r.acc     = acc;
      r.st      = st;
      go_digits = 1'b0;
      v         = '0;
      unique case (st)
         y4m_sd_pkg::NUM_LEAD: begin
            if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) begin
               r.st = st;
            end else if (b == CH_PLUS) begin
               r.st = y4m_sd_pkg::NUM_DIGITS;
            end else if (b == CH_MINUS) begin
               r.st = y4m_sd_pkg::NUM_NEG;
            end else begin
               r.st      = y4m_sd_pkg::NUM_DIGITS;
               go_digits = 1'b1;
            end
         end
         y4m_sd_pkg::NUM_DIGITS: go_digits = 1'b1;
         y4m_sd_pkg::NUM_ENDED,
         y4m_sd_pkg::NUM_NEG:    go_digits = 1'b0;
      endcase
      if (go_digits) begin
         if (b >= CH_ZERO && b <= CH_NINE) begin
            v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + {{(RW){1'b0}}, b[3:0]};
            r.acc = (v > {4'b0000, maxv}) ? maxv : v[RW-1:0];
         end else begin
            r.st = y4m_sd_pkg::NUM_ENDED;
         end
      end
      return r;
   endfunction

   y4m_sd_pkg::phase_type     phase_ff, phase_in, phase_cur;
   y4m_sd_pkg::num_state_type num_state_ff, num_state_in, num_state_cur;
   logic [7:0]                prev_ff, prev_in, prev_cur;
   logic [2:0]                marker_ff, marker_in, marker_cur;
   logic [DW-1:0]             width_ff, width_in, width_cur;
   logic [DW-1:0]             height_ff, height_in, height_cur;
   logic [RW-1:0]             rate_ff, rate_in, rate_cur;
   logic [HW-1:0]             hcount_ff, hcount_in, hcount_cur, hcount_next;
   logic [LW-1:0]             frame_len_ff, frame_len_in;
   logic [LW-1:0]             bytes_left_ff, bytes_left_in, bytes_left_cur;
   logic [CW-1:0]             chunk_left_ff, chunk_left_in, chunk_left_cur;
   logic [PW-1:0]             prod_ff;
   logic [PW+1:0]             prod3;

   logic                      accept;
   logic [7:0]                b;
   logic [RW-1:0]             num_acc_sel, num_max_sel;
   num_result_type            ns;
   logic                      num_active;
   logic                      tag_hit;
   logic [2:0]                seek_marker;
   logic                      frame_found, fields_zero, key_hit, window_end, mark_ok;
   logic                      fend, cend;
   logic [7:0]                want;
   logic [CW-1:0]             chunk_size;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign b         = req_item.stream_byte;

   // a restart byte sees a freshly cleared parser
   assign phase_cur      = req_item.restart ? y4m_sd_pkg::PH_SEEK_W : phase_ff;
   assign num_state_cur  = req_item.restart ? y4m_sd_pkg::NUM_LEAD : num_state_ff;
   assign prev_cur       = req_item.restart ? 8'h00 : prev_ff;
   assign marker_cur     = req_item.restart ? 3'd0 : marker_ff;
   assign width_cur      = req_item.restart ? '0 : width_ff;
   assign height_cur     = req_item.restart ? '0 : height_ff;
   assign rate_cur       = req_item.restart ? '0 : rate_ff;
   assign hcount_cur     = req_item.restart ? '0 : hcount_ff;
   assign bytes_left_cur = req_item.restart ? '0 : bytes_left_ff;
   assign chunk_left_cur = req_item.restart ? '0 : chunk_left_ff;

   always_comb begin
      if (chunk_bytes == '0) begin
         chunk_size = CW'(1);
      end else if (chunk_bytes > y4m_sd_pkg::CHUNK_MAX) begin
         chunk_size = y4m_sd_pkg::CHUNK_MAX;
      end else begin
         chunk_size = chunk_bytes;
      end
   end

   // number reader input follows the field being read
   always_comb begin
      num_active  = 1'b1;
      num_acc_sel = rate_cur;
      num_max_sel = {RW{1'b1}};
      unique case (phase_cur)
         y4m_sd_pkg::PH_SEEK_H: begin
            num_acc_sel = {{(RW-DW){1'b0}}, width_cur};
            num_max_sel = {{(RW-DW){1'b0}}, {DW{1'b1}}};
         end
         y4m_sd_pkg::PH_SEEK_F: begin
            num_acc_sel = {{(RW-DW){1'b0}}, height_cur};
            num_max_sel = {{(RW-DW){1'b0}}, {DW{1'b1}}};
         end
         y4m_sd_pkg::PH_SEEK_FRAME: num_active = 1'b1;
         default:                   num_active = 1'b0;
      endcase
   end

   assign ns = num_step(num_acc_sel, num_state_cur, b, num_max_sel);

   always_comb begin
      unique case (phase_cur)
         y4m_sd_pkg::PH_SEEK_W: want = CH_W;
         y4m_sd_pkg::PH_SEEK_H: want = CH_H;
         default:               want = CH_F;
      endcase
   end

   assign tag_hit     = (b == y4m_sd_pkg::frame_tag(marker_cur));
   assign seek_marker = (tag_hit && marker_cur < y4m_sd_pkg::TAG_LAST) ? marker_cur + 3'd1 :
                        ((b == CH_F) ? 3'd1 : 3'd0);
   assign frame_found = (phase_cur == y4m_sd_pkg::PH_SEEK_FRAME) &&
                        (seek_marker == y4m_sd_pkg::TAG_LAST);
   assign fields_zero = (width_cur == '0) || (height_cur == '0) || (ns.acc == '0);
   assign key_hit     = (phase_cur != y4m_sd_pkg::PH_SEEK_FRAME) && (prev_cur == CH_SPACE) &&
                        (b == want);
   assign hcount_next = hcount_cur + HW'(1);
   assign window_end  = (hcount_next >= HW'(y4m_sd_pkg::HEADER_WINDOW));
   assign mark_ok     = (marker_cur < y4m_sd_pkg::TAG_LEN) && tag_hit;
   assign fend        = (bytes_left_cur <= LW'(1));
   assign cend        = fend || (chunk_left_cur <= CW'(1));

   assign prod3 = {2'b00, prod_ff} + {1'b0, prod_ff, 1'b0};

   // next phase
   always_comb begin
      phase_in = phase_cur;
      unique case (phase_cur)
         y4m_sd_pkg::PH_SEEK_W,
         y4m_sd_pkg::PH_SEEK_H,
         y4m_sd_pkg::PH_SEEK_F,
         y4m_sd_pkg::PH_SEEK_FRAME: begin
            priority if (frame_found) begin
               phase_in = fields_zero ? y4m_sd_pkg::PH_DONE : y4m_sd_pkg::PH_MARKER;
            end else if (window_end) begin
               phase_in = y4m_sd_pkg::PH_DONE;
            end else if (key_hit) begin
               unique case (phase_cur)
                  y4m_sd_pkg::PH_SEEK_W: phase_in = y4m_sd_pkg::PH_SEEK_H;
                  y4m_sd_pkg::PH_SEEK_H: phase_in = y4m_sd_pkg::PH_SEEK_F;
                  default:               phase_in = y4m_sd_pkg::PH_SEEK_FRAME;
               endcase
            end else begin
               phase_in = phase_cur;
            end
         end
         y4m_sd_pkg::PH_MARKER: begin
            if (!mark_ok) begin
               phase_in = y4m_sd_pkg::PH_DONE;
            end else if (marker_cur == y4m_sd_pkg::TAG_LAST) begin
               phase_in = y4m_sd_pkg::PH_PAYLOAD;
            end else begin
               phase_in = y4m_sd_pkg::PH_MARKER;
            end
         end
         y4m_sd_pkg::PH_PAYLOAD: phase_in = fend ? y4m_sd_pkg::PH_MARKER : y4m_sd_pkg::PH_PAYLOAD;
         default:                phase_in = y4m_sd_pkg::PH_DONE;
      endcase
   end

   // datapath updates and queue commands
   always_comb begin
      num_state_in  = num_state_cur;
      prev_in       = prev_cur;
      marker_in     = marker_cur;
      width_in      = width_cur;
      height_in     = height_cur;
      rate_in       = rate_cur;
      hcount_in     = hcount_cur;
      frame_len_in  = frame_len_ff;
      bytes_left_in = bytes_left_cur;
      chunk_left_in = chunk_left_cur;
      push_valid    = 1'b0;
      push_item     = '0;

      unique case (phase_cur)
         y4m_sd_pkg::PH_SEEK_W,
         y4m_sd_pkg::PH_SEEK_H,
         y4m_sd_pkg::PH_SEEK_F,
         y4m_sd_pkg::PH_SEEK_FRAME: begin
            if (num_active) begin
               num_state_in = ns.st;
            end
            unique case (phase_cur)
               y4m_sd_pkg::PH_SEEK_H:     width_in  = ns.acc[DW-1:0];
               y4m_sd_pkg::PH_SEEK_F:     height_in = ns.acc[DW-1:0];
               y4m_sd_pkg::PH_SEEK_FRAME: rate_in   = ns.acc;
               default:                   rate_in   = rate_cur;
            endcase
            if (phase_cur == y4m_sd_pkg::PH_SEEK_FRAME) begin
               marker_in = seek_marker;
            end
            if (frame_found) begin
               push_valid = accept;
               if (fields_zero) begin
                  push_item.kind = y4m_sd_pkg::KIND_HDR_REJECT;
               end else begin
                  push_item.kind   = y4m_sd_pkg::KIND_HDR_OK;
                  push_item.width  = width_cur;
                  push_item.height = height_cur;
                  push_item.rate   = ns.acc;
                  frame_len_in     = prod3[LW:1];
               end
            end else begin
               if (key_hit) begin
                  num_state_in = y4m_sd_pkg::NUM_LEAD;
                  marker_in    = 3'd0;
               end
               prev_in   = key_hit ? 8'h00 : b;
               hcount_in = hcount_next;
               if (window_end) begin
                  push_valid     = accept;
                  push_item.kind = y4m_sd_pkg::KIND_HDR_REJECT;
               end
            end
         end
         y4m_sd_pkg::PH_MARKER: begin
            if (mark_ok) begin
               marker_in = marker_cur + 3'd1;
               if (marker_cur == y4m_sd_pkg::TAG_LAST) begin
                  bytes_left_in = frame_len_ff;
                  chunk_left_in = chunk_size;
               end
            end else begin
               push_valid     = accept;
               push_item.kind = y4m_sd_pkg::KIND_BAD_MARKER;
            end
         end
         y4m_sd_pkg::PH_PAYLOAD: begin
            push_valid          = accept;
            push_item.kind      = y4m_sd_pkg::KIND_PAYLOAD;
            push_item.data      = b;
            push_item.chunk_end = cend;
            push_item.frame_end = fend;
            if (fend) begin
               marker_in     = 3'd0;
               bytes_left_in = '0;
               chunk_left_in = '0;
            end else begin
               bytes_left_in = bytes_left_cur - LW'(1);
               chunk_left_in = cend ? chunk_size : chunk_left_cur - CW'(1);
            end
         end
         default: push_valid = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= y4m_sd_pkg::PH_SEEK_W;
         num_state_ff  <= y4m_sd_pkg::NUM_LEAD;
         prev_ff       <= '0;
         marker_ff     <= '0;
         width_ff      <= '0;
         height_ff     <= '0;
         rate_ff       <= '0;
         hcount_ff     <= '0;
         frame_len_ff  <= '0;
         bytes_left_ff <= '0;
         chunk_left_ff <= '0;
      end else if (accept) begin
         phase_ff      <= phase_in;
         num_state_ff  <= num_state_in;
         prev_ff       <= prev_in;
         marker_ff     <= marker_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
         rate_ff       <= rate_in;
         hcount_ff     <= hcount_in;
         frame_len_ff  <= frame_len_in;
         bytes_left_ff <= bytes_left_in;
         chunk_left_ff <= chunk_left_in;
      end
   end

   // width and height settle well before the tag ends, so a registered product is ready
   always_ff @(posedge clock) begin
      prod_ff <= {{DW{1'b0}}, width_ff} * {{DW{1'b0}}, height_ff};
   end

endmodule

`default_nettype wire

// ===== src/y4m_sd_queue.sv =====
// short command queue between the parser and the emitter
// first-word fall-through, register based; uses y4m_sd_pkg
`default_nettype none

module y4m_sd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  y4m_sd_pkg::cmd_type push_item,
   output logic                full,
   input  logic                pop,
   output y4m_sd_pkg::cmd_type pop_item,
   output logic                empty
);

   localparam int AW = y4m_sd_pkg::QUEUE_PTR_W;
   localparam int NW = y4m_sd_pkg::QUEUE_CNT_W;

   y4m_sd_pkg::cmd_type slot_ff [y4m_sd_pkg::QUEUE_DEPTH];
   logic [AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]       count_ff, count_in;
   logic                do_pop;

   assign full     = (count_ff == NW'(y4m_sd_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_item = slot_ff[rd_ptr_ff];
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + AW'(1) : rd_ptr_ff;
      unique case ({push_valid, do_pop})
         2'b10:   count_in = count_ff + NW'(1);
         2'b01:   count_in = count_ff - NW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> !full)
      else $error("command pushed into a full queue");
`endif

endmodule

`default_nettype wire

// ===== src/y4m_sd_back.sv =====
// emitter: runs queued commands, divides for the tick step, stamps frame time
// and holds the result register; uses y4m_sd_pkg
`default_nettype none

module y4m_sd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     queue_empty,
   input  y4m_sd_pkg::cmd_type      queue_item,
   output logic                     queue_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output y4m_sd_pkg::rsp_item_type rsp_item
);

   localparam int DW = y4m_sd_pkg::DIM_W;
   localparam int RW = y4m_sd_pkg::RATE_W;
   localparam int TW = y4m_sd_pkg::TICK_W;
   localparam int KW = y4m_sd_pkg::DIV_CNT_W;
   localparam int FW = y4m_sd_pkg::COUNT_W;
   localparam int XW = y4m_sd_pkg::TIME_W;

   y4m_sd_pkg::back_state_type state_ff, state_in;
   logic [KW-1:0]              div_cnt_ff, div_cnt_in;
   logic [RW:0]                rem_ff, rem_in, rem_sh;
   logic [TW-1:0]              quot_ff, quot_in;
   logic [RW-1:0]              divisor_ff, divisor_in;
   logic [DW-1:0]              hdr_w_ff, hdr_w_in, hdr_h_ff, hdr_h_in;
   logic [TW-1:0]              step_ff, step_in;
   logic [FW-1:0]              frame_count_ff, frame_count_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   y4m_sd_pkg::rsp_item_type   rsp_item_ff, rsp_item_in;

   logic                       out_free, is_hdr, load_cmd, load_hdr, div_start, rem_ge;
   logic [FW+TW-1:0]           time_prod;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_hdr    = (queue_item.kind == y4m_sd_pkg::KIND_HDR_OK);
   assign rem_sh    = {rem_ff[RW-1:0], y4m_sd_pkg::TICK_RATE[div_cnt_ff]};
   assign rem_ge    = (rem_sh >= {1'b0, divisor_ff});
   assign time_prod = {{TW{1'b0}}, frame_count_ff} * {{FW{1'b0}}, step_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         y4m_sd_pkg::BK_IDLE:
            state_in = (!queue_empty && is_hdr) ? y4m_sd_pkg::BK_DIVIDE : y4m_sd_pkg::BK_IDLE;
         y4m_sd_pkg::BK_DIVIDE:
            state_in = (div_cnt_ff == '0) ? y4m_sd_pkg::BK_EMIT : y4m_sd_pkg::BK_DIVIDE;
         y4m_sd_pkg::BK_EMIT:
            state_in = out_free ? y4m_sd_pkg::BK_IDLE : y4m_sd_pkg::BK_EMIT;
         default:
            state_in = y4m_sd_pkg::BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      load_cmd  = (state_ff == y4m_sd_pkg::BK_IDLE) && !queue_empty && !is_hdr && out_free;
      div_start = (state_ff == y4m_sd_pkg::BK_IDLE) && !queue_empty && is_hdr;
      load_hdr  = (state_ff == y4m_sd_pkg::BK_EMIT) && out_free;
      queue_pop = load_cmd || div_start;

      div_cnt_in     = div_cnt_ff;
      rem_in         = rem_ff;
      quot_in        = quot_ff;
      divisor_in     = divisor_ff;
      hdr_w_in       = hdr_w_ff;
      hdr_h_in       = hdr_h_ff;
      step_in        = step_ff;
      frame_count_in = frame_count_ff;
      rsp_item_in    = rsp_item_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;

      if (div_start) begin
         div_cnt_in = KW'(TW - 1);
         rem_in     = '0;
         quot_in    = '0;
         divisor_in = queue_item.rate;
         hdr_w_in   = queue_item.width;
         hdr_h_in   = queue_item.height;
      end
      // one quotient bit per cycle, dividend bits taken most significant first
      if (state_ff == y4m_sd_pkg::BK_DIVIDE) begin
         rem_in     = rem_ge ? rem_sh - {1'b0, divisor_ff} : rem_sh;
         quot_in    = {quot_ff[TW-2:0], rem_ge};
         div_cnt_in = div_cnt_ff - KW'(1);
      end
      if (load_hdr) begin
         rsp_valid_in             = 1'b1;
         rsp_item_in              = '0;
         rsp_item_in.kind         = y4m_sd_pkg::KIND_HDR_OK;
         rsp_item_in.frame_width  = hdr_w_ff;
         rsp_item_in.frame_height = hdr_h_ff;
         rsp_item_in.tick_step    = quot_ff;
         step_in                  = quot_ff;
         frame_count_in           = '0;
      end
      if (load_cmd) begin
         rsp_valid_in     = 1'b1;
         rsp_item_in      = '0;
         rsp_item_in.kind = queue_item.kind;
         if (queue_item.kind == y4m_sd_pkg::KIND_PAYLOAD) begin
            rsp_item_in.payload_byte = queue_item.data;
            rsp_item_in.frame_time   = time_prod[XW-1:0];
            rsp_item_in.chunk_end    = queue_item.chunk_end;
            rsp_item_in.frame_end    = queue_item.frame_end;
            if (queue_item.frame_end) begin
               frame_count_in = frame_count_ff + FW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= y4m_sd_pkg::BK_IDLE;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         step_ff        <= '0;
         frame_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         div_cnt_ff     <= div_cnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         step_ff        <= step_in;
         frame_count_ff <= frame_count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      divisor_ff  <= divisor_in;
      hdr_w_ff    <= hdr_w_in;
      hdr_h_ff    <= hdr_h_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_no_pop_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != y4m_sd_pkg::BK_IDLE) |-> !queue_pop)
      else $error("queue popped while the divider is busy");

   a_hdr_emitted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == y4m_sd_pkg::BK_EMIT && out_free) |=>
      (rsp_valid_ff && rsp_item_ff.kind == y4m_sd_pkg::KIND_HDR_OK))
      else $error("header result not presented after the divide");

   a_frame_end_chunk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.frame_end) |-> rsp_item_ff.chunk_end)
      else $error("frame end without chunk end");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// testbench for y4m_stream_deframer_unit: drives YUV4MPEG2-style byte streams and
// checks every result against a cycle-free prediction held in a scoreboard class
// depends on y4m_sd_pkg and the deframer RTL

localparam logic [7:0] CH_TAB   = 8'h09;
localparam logic [7:0] CH_CR    = 8'h0D;
localparam logic [7:0] CH_SPACE = 8'h20;
localparam logic [7:0] CH_PLUS  = 8'h2B;
localparam logic [7:0] CH_MINUS = 8'h2D;
localparam logic [7:0] CH_ZERO  = 8'h30;
localparam logic [7:0] CH_NINE  = 8'h39;
localparam logic [7:0] CH_F     = 8'h46;
localparam logic [7:0] CH_H     = 8'h48;
localparam logic [7:0] CH_W     = 8'h57;

localparam logic [47:0]                     FRAME_TAG  = "FRAME\n";
localparam logic [y4m_sd_pkg::RATE_W-1:0]   DIM_MAX    = 20'd65535;
localparam logic [y4m_sd_pkg::RATE_W-1:0]   RATE_MAX   = 20'hFFFFF;
localparam logic [y4m_sd_pkg::CSR_ADDR_W-1:0] CHUNK_ADDR = {y4m_sd_pkg::CSR_IDX_CHUNK, 2'b00};

class deframe_scoreboard;
   logic [y4m_sd_pkg::CHUNK_W-1:0]     chunk_reg;
   y4m_sd_pkg::phase_type              phase;
   y4m_sd_pkg::num_state_type          num_state;
   logic [7:0]                         prev_byte;
   int unsigned                        tag_pos;
   int unsigned                        hdr_count;
   logic [y4m_sd_pkg::RATE_W-1:0]      width_acc;
   logic [y4m_sd_pkg::RATE_W-1:0]      height_acc;
   logic [y4m_sd_pkg::RATE_W-1:0]      rate_acc;
   logic [y4m_sd_pkg::TICK_W-1:0]      step;
   logic [y4m_sd_pkg::FRAME_LEN_W-1:0] frame_len;
   logic [y4m_sd_pkg::FRAME_LEN_W-1:0] bytes_left;
   logic [y4m_sd_pkg::CHUNK_W-1:0]     chunk_left;
   logic [y4m_sd_pkg::COUNT_W-1:0]     frame_count;
   y4m_sd_pkg::rsp_item_type           expected_rsp[$];
   int                                 failures;

   function new();
      chunk_reg = y4m_sd_pkg::CHUNK_RESET;
      failures = 0;
      clear_stream();
   endfunction

   function void clear_stream();
      phase = y4m_sd_pkg::PH_SEEK_W;
      num_state = y4m_sd_pkg::NUM_LEAD;
      prev_byte = 8'h00;
      tag_pos = 0;
      hdr_count = 0;
      width_acc = '0;
      height_acc = '0;
      rate_acc = '0;
      step = '0;
      frame_len = '0;
      bytes_left = '0;
      chunk_left = '0;
      frame_count = '0;
   endfunction

   function void set_chunk(logic [31:0] v);
      chunk_reg = v[y4m_sd_pkg::CHUNK_W-1:0];
   endfunction

   // zero behaves as one, anything past 64k as 64k
   function logic [y4m_sd_pkg::CHUNK_W-1:0] chunk_limit();
      if (chunk_reg == 0) return 1;
      if (chunk_reg > y4m_sd_pkg::CHUNK_MAX) return y4m_sd_pkg::CHUNK_MAX;
      return chunk_reg;
   endfunction

   function logic [7:0] tag_char(int unsigned k);
      return FRAME_TAG[8*(5-k) +: 8];
   endfunction

   // atoi-style reader: leading space, optional sign, saturating digits
   function logic [y4m_sd_pkg::RATE_W-1:0] take_digit(logic [y4m_sd_pkg::RATE_W-1:0] acc,
                                                      logic [7:0] b,
                                                      logic [y4m_sd_pkg::RATE_W-1:0] top);
      longint unsigned grown;
      if (num_state == y4m_sd_pkg::NUM_LEAD) begin
         if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return acc;
         if (b == CH_PLUS) begin
            num_state = y4m_sd_pkg::NUM_DIGITS;
            return acc;
         end
         if (b == CH_MINUS) begin
            num_state = y4m_sd_pkg::NUM_NEG;
            return acc;
         end
         num_state = y4m_sd_pkg::NUM_DIGITS;
      end
      if (num_state == y4m_sd_pkg::NUM_DIGITS) begin
         if (b >= CH_ZERO && b <= CH_NINE) begin
            grown = acc;
            grown = grown * 10 + (b - CH_ZERO);
            return (grown > top) ? top : grown[y4m_sd_pkg::RATE_W-1:0];
         end
         num_state = y4m_sd_pkg::NUM_ENDED;
      end
      return acc;
   endfunction

   function void note_byte(y4m_sd_pkg::req_item_type it);
      y4m_sd_pkg::rsp_item_type r;
      logic [7:0]               b;
      logic [7:0]               want;
      bit                       consumed;
      bit                       fend;
      bit                       cend;
      longint unsigned          prod;
      r = '0;
      b = it.stream_byte;
      consumed = 0;
      if (it.restart) clear_stream();

      if (phase < y4m_sd_pkg::PH_MARKER) begin
         if (phase == y4m_sd_pkg::PH_SEEK_H) width_acc = take_digit(width_acc, b, DIM_MAX);
         else if (phase == y4m_sd_pkg::PH_SEEK_F) height_acc = take_digit(height_acc, b, DIM_MAX);
         else if (phase == y4m_sd_pkg::PH_SEEK_FRAME) rate_acc = take_digit(rate_acc, b, RATE_MAX);

         if (phase == y4m_sd_pkg::PH_SEEK_FRAME) begin
            if (tag_pos < y4m_sd_pkg::TAG_LAST && b == tag_char(tag_pos)) tag_pos++;
            else tag_pos = (b == CH_F) ? 1 : 0;
            if (tag_pos == y4m_sd_pkg::TAG_LAST) begin
               if (width_acc == 0 || height_acc == 0 || rate_acc == 0) begin
                  phase = y4m_sd_pkg::PH_DONE;
                  r.kind = y4m_sd_pkg::KIND_HDR_REJECT;
               end else begin
                  step = y4m_sd_pkg::TICK_RATE / rate_acc;
                  prod = width_acc;
                  prod = prod * height_acc * 3 / 2;
                  frame_len = prod[y4m_sd_pkg::FRAME_LEN_W-1:0];
                  phase = y4m_sd_pkg::PH_MARKER;
                  r.kind = y4m_sd_pkg::KIND_HDR_OK;
                  r.frame_width = width_acc[y4m_sd_pkg::DIM_W-1:0];
                  r.frame_height = height_acc[y4m_sd_pkg::DIM_W-1:0];
                  r.tick_step = step;
               end
               expected_rsp.push_back(r);
               return;
            end
         end else if (prev_byte == CH_SPACE) begin
            want = (phase == y4m_sd_pkg::PH_SEEK_W) ? CH_W :
                   (phase == y4m_sd_pkg::PH_SEEK_H) ? CH_H : CH_F;
            if (b == want) begin
               phase = y4m_sd_pkg::phase_type'(phase + 1);
               num_state = y4m_sd_pkg::NUM_LEAD;
               tag_pos = 0;
               consumed = 1;
            end
         end
         // the marker letter itself never counts as a space for the next search
         prev_byte = consumed ? 8'h00 : b;
         hdr_count++;
         if (hdr_count >= y4m_sd_pkg::HEADER_WINDOW) begin
            phase = y4m_sd_pkg::PH_DONE;
            r.kind = y4m_sd_pkg::KIND_HDR_REJECT;
            expected_rsp.push_back(r);
         end
      end else if (phase == y4m_sd_pkg::PH_MARKER) begin
         if (tag_pos < y4m_sd_pkg::TAG_LEN && b == tag_char(tag_pos)) begin
            tag_pos++;
            if (tag_pos == y4m_sd_pkg::TAG_LEN) begin
               phase = y4m_sd_pkg::PH_PAYLOAD;
               bytes_left = frame_len;
               chunk_left = chunk_limit();
            end
         end else begin
            phase = y4m_sd_pkg::PH_DONE;
            r.kind = y4m_sd_pkg::KIND_BAD_MARKER;
            expected_rsp.push_back(r);
         end
      end else if (phase == y4m_sd_pkg::PH_PAYLOAD) begin
         fend = bytes_left <= 1;
         cend = fend || chunk_left <= 1;
         prod = frame_count;
         prod = prod * step;
         r.kind = y4m_sd_pkg::KIND_PAYLOAD;
         r.payload_byte = b;
         r.frame_time = prod[y4m_sd_pkg::TIME_W-1:0];
         r.chunk_end = cend;
         r.frame_end = fend;
         if (fend) begin
            frame_count++;
            phase = y4m_sd_pkg::PH_MARKER;
            tag_pos = 0;
            bytes_left = '0;
            chunk_left = '0;
         end else begin
            bytes_left--;
            chunk_left = cend ? chunk_limit() : chunk_left - 1;
         end
         expected_rsp.push_back(r);
      end
   endfunction

   function void show(string tag, y4m_sd_pkg::rsp_item_type x);
      $display("  %s kind=%0d byte=%h time=%0d chunk_end=%b frame_end=%b w=%0d h=%0d step=%0d",
               tag, x.kind, x.payload_byte, x.frame_time, x.chunk_end, x.frame_end,
               x.frame_width, x.frame_height, x.tick_step);
   endfunction

   function void check_rsp(y4m_sd_pkg::rsp_item_type got);
      y4m_sd_pkg::rsp_item_type want;
      bit                       bad;
      if (expected_rsp.size() == 0) begin
         failures++;
         if (failures <= 10) show("unexpected", got);
         return;
      end
      want = expected_rsp.pop_front();
      bad = (got.kind !== want.kind) || (got.payload_byte !== want.payload_byte) ||
            (got.frame_time !== want.frame_time) || (got.chunk_end !== want.chunk_end) ||
            (got.frame_end !== want.frame_end) || (got.frame_width !== want.frame_width) ||
            (got.frame_height !== want.frame_height) || (got.tick_step !== want.tick_step);
      if (bad) begin
         failures++;
         if (failures <= 10) begin
            $display("result mismatch at %0t", $time);
            show("expected", want);
            show("actual  ", got);
         end
      end
   endfunction
endclass

module testbench;
   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   y4m_sd_pkg::req_item_type            req_item = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   y4m_sd_pkg::rsp_item_type            rsp_item;
   logic                                csr_psel = 1'b0;
   logic                                csr_penable = 1'b0;
   logic                                csr_pwrite = 1'b0;
   logic [y4m_sd_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [y4m_sd_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [y4m_sd_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                                csr_pready;

   deframe_scoreboard     sb;
   logic [7:0]            stream_q[$];
   logic [31:0]           chunk_plan[8];
   int unsigned           sent = 0;
   int unsigned           stall_left = 0;
   bit                    idling = 0;

   y4m_stream_deframer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_item    (rsp_item),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   initial begin
      #10_000_000;
      $display("timeout at %0t", $time);
      $display("RESULT: ERROR");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
         if (idling && $urandom_range(0, 9) == 0) stall_left = gap_len();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) sb.check_rsp(rsp_item);
   end

   task automatic send_byte(input logic [7:0] b, input bit restart);
      y4m_sd_pkg::req_item_type it;
      int unsigned              gap;
      it.stream_byte = b;
      it.restart = restart;
      gap = (idling && $urandom_range(0, 5) == 0) ? gap_len() : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_byte(it);
      sent++;
   endtask

   task automatic wait_idle();
      int unsigned spins;
      spins = 0;
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0 && spins < 20000) begin
         @(posedge clock);
         spins++;
      end
      // the tick-step divide can still be running after the last byte
      repeat (40) @(posedge clock);
   endtask

   task automatic check_chunk_reg(input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= CHUNK_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      if (csr_prdata !== {{(y4m_sd_pkg::CSR_DATA_W-y4m_sd_pkg::CHUNK_W){1'b0}},
                          v[y4m_sd_pkg::CHUNK_W-1:0]}) begin
         sb.failures++;
         if (sb.failures <= 10)
            $display("chunk_bytes read %h, expected %h", csr_prdata,
                     v[y4m_sd_pkg::CHUNK_W-1:0]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_chunk(input logic [31:0] v);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CHUNK_ADDR;
      csr_pwdata <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.set_chunk(v);
      check_chunk_reg(v);
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) stream_q.push_back(s[i]);
   endtask

   task automatic add_random(input int unsigned n);
      repeat (n) stream_q.push_back($urandom_range(0, 255));
   endtask

   // lowercase filler that can never complete a marker
   task automatic add_filler(input int unsigned n);
      repeat (n) stream_q.push_back($urandom_range(8'h61, 8'h7A));
   endtask

   task automatic add_marker(output bit intact);
      int unsigned bad_at;
      logic [7:0]  ch;
      bad_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 5) : 6;
      for (int i = 0; i < 6; i++) begin
         ch = FRAME_TAG[8*(5-i) +: 8];
         if (i == bad_at) ch = ch ^ $urandom_range(1, 255);
         stream_q.push_back(ch);
      end
      intact = (bad_at == 6);
   endtask

   function automatic string dim_field(output int v);
      int unsigned r;
      r = $urandom_range(0, 99);
      v = 0;
      if (r < 80) begin
         v = $urandom_range(1, 8);
         return $sformatf("%0d", v);
      end
      if (r < 86) begin
         v = $urandom_range(9, 16);
         return $sformatf("%0d", v);
      end
      if (r < 89) return "0";
      if (r < 92) return $sformatf("-%0d", $urandom_range(1, 9));
      if (r < 95) begin
         v = 65535;
         return "1234567";
      end
      if (r < 98) begin
         v = $urandom_range(1, 8);
         return $sformatf(" \t+%0d", v);
      end
      return "";
   endfunction

   function automatic string rate_field(output int v);
      int unsigned r;
      r = $urandom_range(0, 99);
      v = 0;
      if (r < 80) begin
         v = $urandom_range(1, 60);
         return $sformatf("%0d:1", v);
      end
      if (r < 85) begin
         v = $urandom_range(61, 90000);
         return $sformatf("%0d:1001", v);
      end
      if (r < 88) begin
         v = $urandom_range(90001, 1000000);
         return $sformatf("%0d:1", v);
      end
      if (r < 91) begin
         v = 1048575;
         return "99999999";
      end
      if (r < 94) return "0:1";
      if (r < 97) return "-25:1";
      return "";
   endfunction

   task automatic build_stream();
      string       txt;
      int          w;
      int          h;
      int          fps;
      int unsigned pick;
      int unsigned len;
      int unsigned frames;
      bit          intact;
      stream_q.delete();
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 1)) add_text("YUV4MPEG2");
      if (pick < 3) add_filler($urandom_range(90, 100));
      txt = dim_field(w);
      add_text({" W", txt});
      txt = dim_field(h);
      add_text({" H", txt});
      if ($urandom_range(0, 2) == 0) add_text(" Ip A1:1");
      txt = rate_field(fps);
      add_text({" F", txt});
      if ($urandom_range(0, 2) == 0) add_text(" C420jpeg");
      add_text("\n");
      // header that never reaches FRAME inside the window
      if (pick >= 3 && pick < 6) begin
         add_filler($urandom_range(90, 100));
         return;
      end
      add_marker(intact);
      if (!intact) begin
         add_random(3);
         return;
      end
      if (w <= 0 || h <= 0 || fps <= 0 || w >= 65535 || h >= 65535) begin
         // rejected or huge frame: some bytes, then the next stream restarts
         add_random($urandom_range(0, 30));
         return;
      end
      len = w * h * 3 / 2;
      frames = $urandom_range(1, 3);
      for (int f = 0; f < frames; f++) begin
         if (f > 0) begin
            add_marker(intact);
            if (!intact) begin
               add_random(3);
               return;
            end
         end
         if ($urandom_range(0, 24) == 0) begin
            add_random($urandom_range(0, len));
            return;
         end
         add_random(len);
      end
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_q.size(); i++) send_byte(stream_q[i], i == 0);
   endtask

   task automatic send_noise();
      int unsigned n;
      n = $urandom_range(10, 40);
      for (int k = 0; k < n; k++)
         send_byte($urandom_range(0, 255), k == 0 || $urandom_range(0, 15) == 0);
   endtask

   initial begin
      int unsigned target;
      sb = new();
      chunk_plan = '{32'd8192, 32'd1, 32'd3, 32'd0, 32'd65536, 32'h1FFFF, 32'd2, 32'd0};
      chunk_plan[7] = $urandom_range(4, 300);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_chunk_reg(y4m_sd_pkg::CHUNK_RESET);

      // accepted header with a rate above 90000, one tiny frame, then a broken marker
      stream_q.delete();
      add_text(" W1 H2 F99999FRAME\n");
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hFF);
      stream_q.push_back(8'h5A);
      add_text("FRAMX");
      stream_q.push_back(8'h33);
      send_stream();
      wait_idle();

      for (int p = 0; p < 8; p++) begin
         write_chunk(chunk_plan[p]);
         idling = (p % 4) != 1;
         // a stream in flight runs past the target, about 50 bytes on average
         target = sent + 190;
         while (sent < target) begin
            if ($urandom_range(0, 32) == 0) send_noise();
            else begin
               build_stream();
               send_stream();
            end
         end
         wait_idle();
      end

      if (sb.expected_rsp.size() != 0) begin
         $display("%0d expected results never arrived", sb.expected_rsp.size());
         sb.failures += sb.expected_rsp.size();
      end
      if (sb.failures == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule
